// ===== hdl/irtfq_pkg.sv =====
// ----------------------------------------------------------------------------
// IR thermometer frame qualifier package
// Shared types, register indexes, status codes and the SMBus PEC helper.
// ----------------------------------------------------------------------------
package irtfq_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_DEVICE_ADDRESS  = 3'd0;
	localparam logic [2:0] REG_OBJECT_COMMAND  = 3'd1;
	localparam logic [2:0] REG_AMBIENT_COMMAND = 3'd2;
	localparam logic [2:0] REG_TEMP_OFFSET     = 3'd3;
	localparam logic [2:0] REG_TEMP_MIN        = 3'd4;
	localparam logic [2:0] REG_TEMP_MAX        = 3'd5;
	localparam logic [2:0] REG_FAIL_LIMIT      = 3'd6;

	// Register reset values.
	localparam logic [6:0]         RST_DEVICE_ADDRESS  = 7'd90;
	localparam logic [7:0]         RST_OBJECT_COMMAND  = 8'd7;
	localparam logic [7:0]         RST_AMBIENT_COMMAND = 8'd6;
	localparam logic signed [11:0] RST_TEMP_OFFSET     = 12'sd0;
	localparam logic signed [16:0] RST_TEMP_MIN        = 17'sd2000;
	localparam logic signed [16:0] RST_TEMP_MAX        = 17'sd4500;
	localparam logic [7:0]         RST_FAIL_LIMIT      = 8'd3;

	// Kelvin to Celsius offset in centidegrees.
	localparam logic signed [16:0] KELVIN_CENTI = 17'sd27315;
	localparam logic [7:0]         CRC_POLY     = 8'h07;
	localparam logic [7:0]         COUNT_MAX    = 8'd255;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BUS_FAIL  = 3'd1,
		ST_PEC_BAD   = 3'd2,
		ST_ERR_FLAG  = 3'd3,
		ST_OUT_RANGE = 3'd4
	} status_t;

	// Outcome of checking one read frame.
	typedef struct packed {
		status_t            status;
		logic signed [16:0] centi;
	} frame_res_t;

	// Input beat, last field in the lowest bits.
	typedef struct packed {
		logic [5:0] pad;
		logic       amb_bus_ok;
		logic [7:0] amb_pec;
		logic [7:0] amb_high;
		logic [7:0] amb_low;
		logic       obj_bus_ok;
		logic [7:0] obj_pec;
		logic [7:0] obj_high;
		logic [7:0] obj_low;
	} in_beat_t;

	// Result beat, last field in the lowest bits.
	typedef struct packed {
		logic               pad;
		logic [7:0]         fail_count;
		logic               data_valid;
		logic signed [16:0] ambient_temp;
		logic signed [16:0] object_temp;
		status_t            status;
		logic               accepted;
	} out_beat_t;

	// One byte of the SMBus CRC-8, MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== hdl/irtfq_frame_check.sv =====
// ----------------------------------------------------------------------------
// IR thermometer frame check
// Checks one SMBus read frame (bus, PEC, error flag) and converts its raw
// value to centidegrees Celsius.
// ----------------------------------------------------------------------------
module irtfq_frame_check (
	input  logic [6:0]            dev_addr,
	input  logic [7:0]            command,
	input  logic [7:0]            lo,
	input  logic [7:0]            hi,
	input  logic [7:0]            pec,
	input  logic                  bus_ok,
	output irtfq_pkg::frame_res_t res
);
	import irtfq_pkg::*;

	logic [7:0] crc;

	// PEC covers write address, command, read address, low and high byte.
	always_comb begin
		crc = crc8_byte(8'h00, {dev_addr, 1'b0});
		crc = crc8_byte(crc, command);
		crc = crc8_byte(crc, {dev_addr, 1'b1});
		crc = crc8_byte(crc, lo);
		crc = crc8_byte(crc, hi);
	end

	always_comb begin
		// Raw LSB is 0.02 K, so centidegrees are twice the raw value minus 273.15 K.
		res.centi = signed'({1'b0, hi[6:0], lo, 1'b0}) - KELVIN_CENTI;
		priority if (!bus_ok) begin
			res.status = ST_BUS_FAIL;
		end else if (crc != pec) begin
			res.status = ST_PEC_BAD;
		end else if (hi[7]) begin
			res.status = ST_ERR_FLAG;
		end else begin
			res.status = ST_OK;
		end
	end

endmodule

// ===== hdl/ir_thermometer_frame_qualifier_top.sv =====
// ----------------------------------------------------------------------------
// IR thermometer frame qualifier, top level
// Qualifies object and ambient read frames and keeps the filtered readings.
// ----------------------------------------------------------------------------
// Each input beat carries one measurement: the object and the ambient read
// frames of the sensor. The object frame must have completed on the bus, carry
// a matching SMBus PEC (CRC-8, polynomial 0x07) and have its error flag clear;
// its value, converted to centidegrees Celsius plus the calibration offset,
// must then lie within [temp_min, temp_max]. A good measurement stores the
// object value, clears the fail count and sets data_valid; the ambient value
// is stored only when its own frame is good. A failed measurement raises the
// saturating fail count and drops data_valid once the count reaches
// fail_limit. Every input beat yields exactly one result beat. The block
// takes one beat per cycle while the result stream is not stalled: a beat is
// registered on entry, then checked and written to the result register; the
// one-deep input and result registers hold their beats while m_tready is low.
// Configuration writes are always taken and must be made while no measurement
// is in flight.
// ----------------------------------------------------------------------------
module ir_thermometer_frame_qualifier_top (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	// obj_low[7:0], obj_high[15:8], obj_pec[23:16], obj_bus_ok[24],
	// amb_low[32:25], amb_high[40:33], amb_pec[48:41], amb_bus_ok[49], zero pad
	input  logic [55:0] s_tdata,
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], status[3:1], object_temp[20:4], ambient_temp[37:21],
	// data_valid[38], fail_count[46:39], zero pad[47]
	output logic [47:0] m_tdata,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data
);
	import irtfq_pkg::*;

	// Configuration registers.
	logic [6:0]         dev_addr_q;
	logic [7:0]         obj_cmd_q;
	logic [7:0]         amb_cmd_q;
	logic signed [11:0] offset_q;
	logic signed [16:0] tmin_q;
	logic signed [16:0] tmax_q;
	logic [7:0]         limit_q;

	// Measurement state.
	logic signed [16:0] obj_temp_q;
	logic signed [16:0] amb_temp_q;
	logic [7:0]         count_q;
	logic               valid_q;

	// Input register and result register.
	in_beat_t  beat_s1;
	logic      vld_s1;
	out_beat_t res_s2;
	logic      vld_s2;
	logic      advance;

	frame_res_t         obj_res;
	frame_res_t         amb_res;
	logic signed [16:0] obj_value;
	logic               in_range;
	logic               accept;
	status_t            status;
	logic signed [16:0] obj_temp_d;
	logic signed [16:0] amb_temp_d;
	logic [7:0]         count_d;
	logic               valid_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= RST_DEVICE_ADDRESS;
			obj_cmd_q  <= RST_OBJECT_COMMAND;
			amb_cmd_q  <= RST_AMBIENT_COMMAND;
			offset_q   <= RST_TEMP_OFFSET;
			tmin_q     <= RST_TEMP_MIN;
			tmax_q     <= RST_TEMP_MAX;
			limit_q    <= RST_FAIL_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS:  dev_addr_q <= cfg_data[6:0];
				REG_OBJECT_COMMAND:  obj_cmd_q  <= cfg_data[7:0];
				REG_AMBIENT_COMMAND: amb_cmd_q  <= cfg_data[7:0];
				REG_TEMP_OFFSET:     offset_q   <= signed'(cfg_data[11:0]);
				REG_TEMP_MIN:        tmin_q     <= signed'(cfg_data);
				REG_TEMP_MAX:        tmax_q     <= signed'(cfg_data);
				REG_FAIL_LIMIT:      limit_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The held beat moves on whenever the result register is free or being
	// emptied, so a new beat can enter while a result waits.
	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1 <= in_beat_t'(s_tdata);
		end
	end

	irtfq_frame_check u_obj_check (
		.dev_addr (dev_addr_q),
		.command  (obj_cmd_q),
		.lo       (beat_s1.obj_low),
		.hi       (beat_s1.obj_high),
		.pec      (beat_s1.obj_pec),
		.bus_ok   (beat_s1.obj_bus_ok),
		.res      (obj_res)
	);

	irtfq_frame_check u_amb_check (
		.dev_addr (dev_addr_q),
		.command  (amb_cmd_q),
		.lo       (beat_s1.amb_low),
		.hi       (beat_s1.amb_high),
		.pec      (beat_s1.amb_pec),
		.bus_ok   (beat_s1.amb_bus_ok),
		.res      (amb_res)
	);

	// The converted value plus a 12-bit offset always fits 17 bits.
	assign obj_value = obj_res.centi + 17'(offset_q);
	assign in_range  = (obj_value >= tmin_q) && (obj_value <= tmax_q);
	assign accept    = (obj_res.status == ST_OK) && in_range;

	always_comb begin
		obj_temp_d = obj_temp_q;
		amb_temp_d = amb_temp_q;
		count_d    = count_q;
		valid_d    = valid_q;
		status     = obj_res.status;
		if ((obj_res.status == ST_OK) && !in_range) begin
			status = ST_OUT_RANGE;
		end
		if (accept) begin
			obj_temp_d = obj_value;
			count_d    = 8'd0;
			valid_d    = 1'b1;
			if (amb_res.status == ST_OK) begin
				amb_temp_d = amb_res.centi;
			end
		end else begin
			if (count_q != COUNT_MAX) begin
				count_d = count_q + 8'd1;
			end
			if (count_d >= limit_q) begin
				valid_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_temp_q <= '0;
			amb_temp_q <= '0;
			count_q    <= '0;
			valid_q    <= 1'b0;
			vld_s2     <= 1'b0;
		end else begin
			if (advance) begin
				obj_temp_q <= obj_temp_d;
				amb_temp_q <= amb_temp_d;
				count_q    <= count_d;
				valid_q    <= valid_d;
				vld_s2     <= 1'b1;
			end else if (m_tready) begin
				vld_s2     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.pad          <= 1'b0;
			res_s2.fail_count   <= count_d;
			res_s2.data_valid   <= valid_d;
			res_s2.ambient_temp <= amb_temp_d;
			res_s2.object_temp  <= obj_temp_d;
			res_s2.status       <= status;
			res_s2.accepted     <= accept;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = res_s2;

`ifndef SYNTHESIS
	// An accepted measurement always reports OK, a cleared count and valid data.
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.accepted) |->
		((res_s2.status == ST_OK) && (res_s2.fail_count == 8'd0) && res_s2.data_valid))
		else $error("accepted result with inconsistent status, count or valid");

	// A rejected measurement never reports OK and never clears the count.
	a_reject_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_s2.accepted) |->
		((res_s2.status != ST_OK) && (res_s2.fail_count != 8'd0)))
		else $error("rejected result reports OK or a zero fail count");

	// A held beat whose result register is stalled stays in place.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && !m_tready) |=> vld_s1)
		else $error("input register lost a beat while the output was stalled");
`endif

endmodule
